@@ src/rrc_pkg.sv @@
package rrc_pkg;

  // number of break address registers
  localparam int unsigned NumBreaks = 4;

  // response bytes per register
  localparam int unsigned BytesPerReg = 2;

  // reset value of the maximum response size
  localparam logic [7:0] MaxPduReset = 8'd250;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] REG_GROUP_MODE   = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLLOW_GAP   = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_PDU      = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_BREAK_COUNT  = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_BREAK_ADDR_0 = 4'd4;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic                        group_mode;
    logic [7:0]                  hollow_gap;
    logic [7:0]                  max_pdu_bytes;
    logic [2:0]                  break_count;
    logic [NumBreaks-1:0][15:0]  break_addr;
  } rrc_cfg_t;

  typedef struct packed {
    logic [15:0] start;
    logic [6:0]  count;
    logic [31:0] period;
    logic        group_end;
  } rrc_span_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] count;
    logic [31:0] period;
    logic        last;
  } rrc_result_t;

  // clamp a 17-bit register count to the 16-bit output field
  function automatic logic [15:0] sat_count(input logic [16:0] cnt);
    sat_count = cnt[16] ? 16'hFFFF : cnt[15:0];
  endfunction

endpackage

@@ src/rrc_cfg_regs.sv @@
module rrc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rrc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output rrc_pkg::rrc_cfg_t             cfg_o
);
  import rrc_pkg::*;

  rrc_cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      if (cfg_index_i == REG_GROUP_MODE) cfg_d.group_mode = cfg_wdata_i[0];
      if (cfg_index_i == REG_HOLLOW_GAP) cfg_d.hollow_gap = cfg_wdata_i[7:0];
      if (cfg_index_i == REG_MAX_PDU) cfg_d.max_pdu_bytes = cfg_wdata_i[7:0];
      if (cfg_index_i == REG_BREAK_COUNT) cfg_d.break_count = cfg_wdata_i[2:0];
      for (int i = 0; i < NumBreaks; i++) begin
        if (cfg_index_i == CfgIdxW'(int'(REG_BREAK_ADDR_0) + i)) begin
          cfg_d.break_addr[i] = cfg_wdata_i[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.group_mode    <= 1'b1;
      cfg_q.hollow_gap    <= '0;
      cfg_q.max_pdu_bytes <= MaxPduReset;
      cfg_q.break_count   <= '0;
      cfg_q.break_addr    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/rrc_merge.sv @@
module rrc_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rrc_pkg::rrc_cfg_t        cfg_i,
  input  rrc_pkg::rrc_span_t       span_i,
  input  logic                     update_i,
  output rrc_pkg::rrc_result_t     res_o [2],
  output logic [1:0]               res_num_o
);
  import rrc_pkg::*;

  // open range state
  logic        open_valid_q, open_valid_d;
  logic [15:0] open_start_q, open_start_d;
  logic [16:0] open_count_q, open_count_d;
  logic [31:0] open_period_q, open_period_d;

  logic [16:0] reach;
  logic [17:0] open_end;
  logic [16:0] open_span;
  logic        gap_cut, size_cut, period_cut, brk_cut, grow_open, cut, keep;
  logic [15:0] base_start;
  logic [16:0] base_count;
  logic [31:0] base_period;
  logic [17:0] base_end;
  logic [16:0] new_count;
  rrc_result_t old_res, new_res, span_res;

  // reasons to close the open range
  always_comb begin
    reach      = 17'(span_i.start) + 17'(span_i.count);
    open_end   = 18'(open_start_q) + 18'(open_count_q);
    open_span  = reach - 17'(open_start_q);
    gap_cut    = (open_end + 18'(cfg_i.hollow_gap)) < 18'(span_i.start);
    grow_open  = 18'(reach) > open_end;
    size_cut   = grow_open &&
                 ((19'(open_span) * 19'(BytesPerReg)) > 19'(cfg_i.max_pdu_bytes));
    period_cut = open_period_q != span_i.period;
    brk_cut    = 1'b0;
    for (int i = 0; i < NumBreaks; i++) begin
      if ((3'(i) < cfg_i.break_count) && (open_start_q < cfg_i.break_addr[i]) &&
          (span_i.start >= cfg_i.break_addr[i])) begin
        brk_cut = 1'b1;
      end
    end
    cut  = open_valid_q && (period_cut || brk_cut || gap_cut || size_cut);
    keep = open_valid_q && !cut;
  end

  // range after this span: kept or freshly opened, then grown
  always_comb begin
    base_start  = keep ? open_start_q  : span_i.start;
    base_count  = keep ? open_count_q  : 17'd0;
    base_period = keep ? open_period_q : span_i.period;
    base_end    = 18'(base_start) + 18'(base_count);
    new_count   = (18'(reach) > base_end) ? (reach - 17'(base_start)) : base_count;
  end

  // candidate results
  always_comb begin
    old_res.start  = open_start_q;
    old_res.count  = sat_count(open_count_q);
    old_res.period = open_period_q;
    old_res.last   = 1'b0;
    new_res.start  = base_start;
    new_res.count  = sat_count(new_count);
    new_res.period = base_period;
    new_res.last   = 1'b0;
    span_res.start  = span_i.start;
    span_res.count  = 16'(span_i.count);
    span_res.period = span_i.period;
    span_res.last   = 1'b0;
  end

  // result selection and next state
  always_comb begin
    res_o[0]      = new_res;
    res_o[1]      = new_res;
    res_num_o     = 2'd0;
    open_valid_d  = open_valid_q;
    open_start_d  = open_start_q;
    open_count_d  = open_count_q;
    open_period_d = open_period_q;
    if (!cfg_i.group_mode) begin
      // single mode: flush any open range, then pass the span through
      res_o[0]     = open_valid_q ? old_res : span_res;
      res_o[1]     = span_res;
      res_num_o    = open_valid_q ? 2'd2 : 2'd1;
      open_valid_d = 1'b0;
    end else begin
      if (cut) begin
        res_o[0]  = old_res;
        res_num_o = span_i.group_end ? 2'd2 : 2'd1;
      end else begin
        res_num_o = span_i.group_end ? 2'd1 : 2'd0;
      end
      open_valid_d  = !span_i.group_end;
      open_start_d  = base_start;
      open_count_d  = new_count;
      open_period_d = base_period;
    end
    // mark the final result of this span
    if (res_num_o == 2'd2) res_o[1].last = 1'b1;
    if (res_num_o == 2'd1) res_o[0].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_valid_q <= 1'b0;
    end else if (update_i) begin
      open_valid_q <= open_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update_i) begin
      open_start_q  <= open_start_d;
      open_count_q  <= open_count_d;
      open_period_q <= open_period_d;
    end
  end

endmodule

@@ src/rrc_out_buf.sv @@
module rrc_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  rrc_pkg::rrc_result_t  res_i [2],
  input  logic [1:0]            res_num_i,
  output logic                  load_ok_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rrc_pkg::rrc_result_t  out_o
);
  import rrc_pkg::*;

  rrc_result_t res_q [2];
  logic [1:0]  cnt_q;
  logic        out_xfer;

  assign out_valid_o = cnt_q != 2'd0;
  assign out_xfer    = out_valid_o && out_ready_i;
  // room for a new pair once the buffer is empty or drains its last entry
  assign load_ok_o   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign out_o       = res_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_num_i;
    end else if (out_xfer) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // result pair, shifted down on each output transfer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q[0] <= res_i[0];
      res_q[1] <= res_i[1];
    end else if (out_xfer) begin
      res_q[0] <= res_q[1];
    end
  end

endmodule

@@ src/register_range_coalescer.sv @@
// Register range coalescer: merges address-sorted register spans into read
// ranges.
// Channels: span input (span_valid_i / span_ready_o) carries start, count,
// period and group_end; range output (range_valid_o / range_ready_i) carries
// start, count, period and last_of_run, which marks the final range caused by
// one span. A span can cause zero, one or two ranges.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i);
// write it only while no span is in flight.
// A span's first range passes through the input register and then the
// result register, which takes it only when the output buffer has room.
// Throughput: one span per cycle while each span yields at most one range
// and the receiver takes each range; a span that yields two ranges holds the
// result register until the single output port has drained the result pair.
// When the receiver stalls, the result register holds, one more span waits
// in the input register, and then span_ready_o drops.
// Reset clears the open range, empties both registers and restores the
// configuration defaults (group mode, gap 0, 250 bytes, no breaks).
module register_range_coalescer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rrc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          span_valid_i,
  output logic                          span_ready_o,
  input  logic [15:0]                   span_start_i,
  input  logic [6:0]                    span_count_i,
  input  logic [31:0]                   span_period_i,
  input  logic                          group_end_i,
  output logic                          range_valid_o,
  input  logic                          range_ready_i,
  output logic [15:0]                   range_start_o,
  output logic [15:0]                   range_count_o,
  output logic [31:0]                   range_period_o,
  output logic                          last_of_run_o
);
  import rrc_pkg::*;

  rrc_cfg_t    cfg;
  rrc_span_t   span_q;
  logic        span_valid_q;
  logic        advance, load_ok;
  rrc_result_t res [2];
  logic [1:0]  res_num;
  rrc_result_t out_res;

  rrc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // input register advances into the result buffer when it has room
  assign advance      = span_valid_q && load_ok;
  assign span_ready_o = !span_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_valid_q <= 1'b0;
    end else if (span_ready_o) begin
      span_valid_q <= span_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (span_ready_o && span_valid_i) begin
      span_q.start     <= span_start_i;
      span_q.count     <= span_count_i;
      span_q.period    <= span_period_i;
      span_q.group_end <= group_end_i;
    end
  end

  rrc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .span_i   (span_q),
    .update_i (advance),
    .res_o    (res),
    .res_num_o(res_num)
  );

  rrc_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_i      (res),
    .res_num_i  (res_num),
    .load_ok_o  (load_ok),
    .out_valid_o(range_valid_o),
    .out_ready_i(range_ready_i),
    .out_o      (out_res)
  );

  assign range_start_o  = out_res.start;
  assign range_count_o  = out_res.count;
  assign range_period_o = out_res.period;
  assign last_of_run_o  = out_res.last;

endmodule

@@ src/rrc_checker.sv @@
module rrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        span_ready_o,
  input logic        range_valid_o,
  input logic        range_ready_i,
  input logic [15:0] range_start_o,
  input logic [15:0] range_count_o,
  input logic [31:0] range_period_o,
  input logic        last_of_run_o
);

  // output held while stalled
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_valid_o && !range_ready_i |=> range_valid_o)
    else $error("range valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_valid_o && !range_ready_i |=>
      $stable(range_start_o) && $stable(range_count_o) &&
      $stable(range_period_o) && $stable(last_of_run_o))
    else $error("range payload changed while stalled");

  // nothing pending and input open as reset is released
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !range_valid_o && span_ready_o)
    else $error("block not idle after reset");

  // an empty output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !range_valid_o |-> span_ready_o)
    else $error("span input stalled with empty output");

  // a non-final range is always followed by its partner
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_valid_o && range_ready_i && !last_of_run_o |=> range_valid_o)
    else $error("second range of a span missing");

endmodule

bind register_range_coalescer rrc_checker u_rrc_checker (.*);

@@ sim/rrc_range_check.sv @@
`timescale 1ns / 1ps

// watches both channels and the config port, predicts the read ranges
// each span transfer causes and compares them with the range transfers
module rrc_range_check
  import rrc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                span_valid_i,
  input  logic                span_ready_i,
  input  logic [15:0]         span_start_i,
  input  logic [6:0]          span_count_i,
  input  logic [31:0]         span_period_i,
  input  logic                group_end_i,
  input  logic                range_valid_i,
  input  logic                range_ready_i,
  input  logic [15:0]         range_start_i,
  input  logic [15:0]         range_count_i,
  input  logic [31:0]         range_period_i,
  input  logic                last_of_run_i,
  output int                  pending_o,
  output int                  mismatches_o
);

  // shadow configuration
  rrc_cfg_t cfg;

  // shadow of the open range
  logic        open_valid;
  logic [15:0] open_start;
  logic [16:0] open_count;
  logic [31:0] open_period;

  rrc_result_t expected_ranges[$];
  int          mismatches = 0;

  assign mismatches_o = mismatches;

  // add one expected range at the tail of the queue
  function automatic void append_expected(input rrc_result_t r);
    expected_ranges.insert(expected_ranges.size(), r);
  endfunction

  // close the open range and return it as a result
  function automatic rrc_result_t close_open_range();
    rrc_result_t r;
    r.start  = open_start;
    r.count  = (open_count > 17'h0FFFF) ? 16'hFFFF : open_count[15:0];
    r.period = open_period;
    r.last   = 1'b0;
    open_valid  = 1'b0;
    open_start  = '0;
    open_count  = '0;
    open_period = '0;
    return r;
  endfunction

  // work out the ranges caused by one span and queue them
  task automatic predict_ranges(input logic [15:0] s, input logic [6:0] c,
                                input logic [31:0] p, input logic grp_end);
    rrc_result_t res[2];
    int          n;
    logic        cut;
    int unsigned used_breaks;
    longint      ls, lc, los, loc, lgap, grow, nc;
    n  = 0;
    ls = longint'(s);
    lc = longint'(c);
    if (!cfg.group_mode) begin
      // single mode: pending open range first, then the span itself
      if (open_valid) begin
        res[n] = close_open_range();
        n++;
      end
      res[n].start  = s;
      res[n].count  = {9'd0, c};
      res[n].period = p;
      res[n].last   = 1'b0;
      n++;
    end else begin
      if (open_valid) begin
        los  = longint'(open_start);
        loc  = longint'(open_count);
        lgap = longint'(cfg.hollow_gap);
        cut  = (open_period != p);
        used_breaks = (cfg.break_count > 3'(NumBreaks)) ? NumBreaks
                                                         : int'(cfg.break_count);
        // break address crossing
        for (int i = 0; i < NumBreaks; i++) begin
          if (i < int'(used_breaks) && open_start < cfg.break_addr[i] &&
              s >= cfg.break_addr[i]) begin
            cut = 1'b1;
          end
        end
        // hole too wide
        if (!cut && los + loc + lgap < ls) cut = 1'b1;
        // response size limit
        grow = ls + lc - los - loc;
        if (!cut && grow > 0 &&
            (loc + grow) * longint'(BytesPerReg) > longint'(cfg.max_pdu_bytes)) begin
          cut = 1'b1;
        end
        if (cut) begin
          res[n] = close_open_range();
          n++;
        end
      end
      if (!open_valid) begin
        open_valid  = 1'b1;
        open_start  = s;
        open_count  = '0;
        open_period = p;
      end
      // extend only when the span reaches past the range end
      grow = ls + lc - longint'(open_start) - longint'(open_count);
      if (grow > 0) begin
        nc = longint'(open_count) + grow;
        open_count = (nc > 64'sh1FFFF) ? 17'h1FFFF : 17'(nc);
      end
      if (grp_end && open_valid) begin
        res[n] = close_open_range();
        n++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) append_expected(res[k]);
  endtask

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // shadow update, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    rrc_result_t want;
    if (!rst_ni) begin
      cfg.group_mode    = 1'b1;
      cfg.hollow_gap    = '0;
      cfg.max_pdu_bytes = MaxPduReset;
      cfg.break_count   = '0;
      cfg.break_addr    = '0;
      open_valid        = 1'b0;
      open_start        = '0;
      open_count        = '0;
      open_period       = '0;
      expected_ranges.delete();
    end else begin
      // config writes; unknown indexes are ignored
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GROUP_MODE:  cfg.group_mode    = cfg_wdata_i[0];
          REG_HOLLOW_GAP:  cfg.hollow_gap    = cfg_wdata_i[7:0];
          REG_MAX_PDU:     cfg.max_pdu_bytes = cfg_wdata_i[7:0];
          REG_BREAK_COUNT: cfg.break_count   = cfg_wdata_i[2:0];
          default: begin
            if (cfg_index_i >= REG_BREAK_ADDR_0 &&
                32'(cfg_index_i) < 32'(REG_BREAK_ADDR_0) + NumBreaks) begin
              cfg.break_addr[2'(cfg_index_i - REG_BREAK_ADDR_0)] = cfg_wdata_i;
            end
          end
        endcase
      end
      // range transfer against the oldest expectation
      if (range_valid_i && range_ready_i) begin
        if (expected_ranges.size() == 0) begin
          $display({"%0t: unexpected range, expected none actual start=%0h",
                    " count=%0h period=%0h last=%0b"},
                   $time, range_start_i, range_count_i, range_period_i, last_of_run_i);
          mismatches++;
        end else begin
          want = expected_ranges.pop_front();
          check_field("range_start", 32'(want.start), 32'(range_start_i));
          check_field("range_count", 32'(want.count), 32'(range_count_i));
          check_field("range_period", want.period, range_period_i);
          check_field("last_of_run", 32'(want.last), 32'(last_of_run_i));
        end
      end
      // span transfer
      if (span_valid_i && span_ready_i) begin
        predict_ranges(span_start_i, span_count_i, span_period_i, group_end_i);
      end
    end
    pending_o = expected_ranges.size();
  end

endmodule

@@ sim/tb_register_range_coalescer.sv @@
`timescale 1ns / 1ps

module tb_register_range_coalescer;
  import rrc_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 4'd15;
  localparam int WatchdogLimit = 1000;
  localparam int DrainPad      = 6;
  localparam int HoldCycles    = 80;
  localparam int PhaseSpans    = 150;
  localparam int NumPhases     = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                span_valid = 1'b0;
  logic                span_ready;
  logic [15:0]         span_start = '0;
  logic [6:0]          span_count = '0;
  logic [31:0]         span_period = '0;
  logic                group_end = 1'b0;
  logic                range_valid;
  logic                range_ready = 1'b0;
  logic [15:0]         range_start;
  logic [15:0]         range_count;
  logic [31:0]         range_period;
  logic                last_of_run;

  int       ranges_pending;
  int       mismatches;
  int       spans_sent = 0;
  int       idle_cycles = 0;
  bit       tx_eager = 1'b0;
  bit       rx_eager = 1'b0;
  bit       rx_hold_req = 1'b0;
  rrc_cfg_t cur_cfg;

  always #2 clk = ~clk;

  register_range_coalescer uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .span_valid_i   (span_valid),
    .span_ready_o   (span_ready),
    .span_start_i   (span_start),
    .span_count_i   (span_count),
    .span_period_i  (span_period),
    .group_end_i    (group_end),
    .range_valid_o  (range_valid),
    .range_ready_i  (range_ready),
    .range_start_o  (range_start),
    .range_count_o  (range_count),
    .range_period_o (range_period),
    .last_of_run_o  (last_of_run)
  );

  rrc_range_check u_range_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .span_valid_i   (span_valid),
    .span_ready_i   (span_ready),
    .span_start_i   (span_start),
    .span_count_i   (span_count),
    .span_period_i  (span_period),
    .group_end_i    (group_end),
    .range_valid_i  (range_valid),
    .range_ready_i  (range_ready),
    .range_start_i  (range_start),
    .range_count_i  (range_count),
    .range_period_i (range_period),
    .last_of_run_i  (last_of_run),
    .pending_o      (ranges_pending),
    .mismatches_o   (mismatches)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((span_valid && span_ready) || (range_valid && range_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("Verification failed");
      $finish;
    end
  end

  // range receiver: random stalls, eager stretches, one long hold-off
  initial begin
    int unsigned wait_cycles;
    @(posedge rst_n);
    forever begin
      if (rx_hold_req) begin
        range_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      wait_cycles = rx_eager ? 0 : $urandom_range(0, 5);
      if (wait_cycles != 0) begin
        range_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      range_ready <= 1'b1;
      do @(posedge clk); while (!range_valid);
    end
  end

  // offer one span and hold it until the transfer
  task automatic offer_span(input logic [15:0] s, input logic [6:0] c,
                            input logic [31:0] p, input logic e);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      span_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    span_valid  <= 1'b1;
    span_start  <= s;
    span_count  <= c;
    span_period <= p;
    group_end   <= e;
    do @(posedge clk); while (!span_ready);
    spans_sent++;
  endtask

  // stop sending and wait until every expected range has come
  task automatic wait_ranges_drained();
    span_valid <= 1'b0;
    do @(negedge clk); while (ranges_pending != 0);
    repeat (DrainPad) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // write every register, then the unused index 15
  task automatic program_config(input rrc_cfg_t c);
    cfg_write(REG_GROUP_MODE, {15'd0, c.group_mode});
    cfg_write(REG_HOLLOW_GAP, {8'd0, c.hollow_gap});
    cfg_write(REG_MAX_PDU, {8'd0, c.max_pdu_bytes});
    cfg_write(REG_BREAK_COUNT, {13'd0, c.break_count});
    for (int i = 0; i < NumBreaks; i++) begin
      cfg_write(REG_BREAK_ADDR_0 + 4'(i), c.break_addr[i]);
    end
    cfg_write(RegUnused, 16'($urandom));
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  // per-phase settings, extremes in the first phases
  function automatic rrc_cfg_t pick_config(input int phase);
    rrc_cfg_t c;
    c.group_mode    = 1'b1;
    c.hollow_gap    = 8'($urandom_range(0, 12));
    c.max_pdu_bytes = 8'($urandom_range(20, 255));
    c.break_count   = 3'($urandom_range(0, 7));
    for (int i = 0; i < NumBreaks; i++) c.break_addr[i] = 16'($urandom);
    case (phase)
      0: begin
        c.hollow_gap    = 8'h00;
        c.max_pdu_bytes = 8'hFF;
      end
      1: begin
        c.hollow_gap    = 8'hFF;
        c.max_pdu_bytes = 8'h00;
        c.break_count   = 3'd7;
        c.break_addr[0] = 16'h0000;
        c.break_addr[3] = 16'hFFFF;
      end
      2: c.group_mode = 1'b0;
      3: begin
        c.hollow_gap    = 8'hFF;
        c.max_pdu_bytes = 8'hFF;
        c.break_count   = 3'd0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // one period group: mostly sorted spans, some overlap and noise
  task automatic send_group();
    int          nspans;
    logic [31:0] period;
    int unsigned addr;
    logic [6:0]  cnt;
    logic        end_flag;
    nspans = $urandom_range(1, 8);
    period = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
    // start near a break address now and then so the cut is reached
    if (cur_cfg.break_count != 0 && $urandom_range(0, 1) == 1) begin
      addr = 32'(cur_cfg.break_addr[2'($urandom_range(0, 3))]) - $urandom_range(0, 30);
    end else begin
      addr = $urandom_range(0, 65535);
    end
    for (int k = 0; k < nspans; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        offer_span(16'($urandom), 7'($urandom),
                   ($urandom_range(0, 1) == 1) ? period : $urandom, 1'($urandom));
      end else begin
        cnt      = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 16));
        end_flag = (k == nspans - 1) && ($urandom_range(0, 9) != 0);
        offer_span(16'(addr), cnt, period, end_flag);
        if ($urandom_range(0, 7) == 0) begin
          addr = addr + $urandom_range(0, 32'(cnt));
        end else begin
          addr = addr + 32'(cnt) + $urandom_range(0, 32'(cur_cfg.hollow_gap) + 3);
        end
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rrc_cfg_t dcfg;
    int       target;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: three spans merged into one range
    cur_cfg.group_mode    = 1'b1;
    cur_cfg.hollow_gap    = '0;
    cur_cfg.max_pdu_bytes = MaxPduReset;
    cur_cfg.break_count   = '0;
    cur_cfg.break_addr    = '0;
    offer_span(16'h0000, 7'd1, 32'h0000_0001, 1'b0);
    offer_span(16'h0001, 7'd2, 32'h0000_0001, 1'b0);
    offer_span(16'h0003, 7'd4, 32'h0000_0001, 1'b1);

    // small gap and size limit with two breaks
    wait_ranges_drained();
    dcfg = cur_cfg;
    dcfg.hollow_gap    = 8'd3;
    dcfg.max_pdu_bytes = 8'd40;
    dcfg.break_count   = 3'd2;
    dcfg.break_addr[0] = 16'd100;
    dcfg.break_addr[1] = 16'd200;
    program_config(dcfg);
    offer_span(16'd10, 7'd1, 32'h0000_00B0, 1'b0);
    offer_span(16'd13, 7'd1, 32'h0000_00B0, 1'b0);   // hole within gap
    offer_span(16'd30, 7'd2, 32'h0000_00B0, 1'b0);   // hole too wide
    offer_span(16'd31, 7'd30, 32'h0000_00B0, 1'b0);  // size limit
    offer_span(16'd35, 7'd2, 32'h0000_00B0, 1'b0);   // inside the range
    offer_span(16'd20, 7'd5, 32'h0000_00B0, 1'b0);   // unsorted
    offer_span(16'd98, 7'd2, 32'h0000_00B0, 1'b0);
    offer_span(16'd100, 7'd3, 32'h0000_00B0, 1'b0);  // first break
    offer_span(16'd104, 7'd1, 32'h0000_00C0, 1'b0);  // period change
    offer_span(16'd105, 7'd0, 32'h0000_00C0, 1'b0);  // zero count
    offer_span(16'd200, 7'd4, 32'h0000_00C0, 1'b1);  // break plus group end
    offer_span(16'hFFC0, 7'd127, 32'hFFFF_FFFF, 1'b1); // past the address space
    offer_span(16'd300, 7'd5, 32'h0000_00D0, 1'b0);  // left open

    // single mode with a range still open, break count too large
    wait_ranges_drained();
    dcfg.group_mode    = 1'b0;
    dcfg.hollow_gap    = 8'hFF;
    dcfg.max_pdu_bytes = 8'h00;
    dcfg.break_count   = 3'd7;
    dcfg.break_addr[0] = 16'h0000;
    dcfg.break_addr[1] = 16'hFFFF;
    dcfg.break_addr[2] = 16'h8000;
    dcfg.break_addr[3] = 16'h5555;
    program_config(dcfg);
    offer_span(16'd400, 7'd7, 32'h0000_00D0, 1'b0);
    offer_span(16'h0000, 7'd0, 32'h0000_0000, 1'b0);
    offer_span(16'hFFFF, 7'd127, 32'hFFFF_FFFF, 1'b1);

    // widest gap and size, all four breaks
    wait_ranges_drained();
    dcfg.group_mode    = 1'b1;
    dcfg.max_pdu_bytes = 8'hFF;
    dcfg.break_addr[0] = 16'd1000;
    dcfg.break_addr[1] = 16'd2000;
    dcfg.break_addr[2] = 16'd3000;
    dcfg.break_addr[3] = 16'hFFFF;
    program_config(dcfg);
    offer_span(16'd2990, 7'd5, 32'h0000_00E0, 1'b0);
    offer_span(16'd3000, 7'd10, 32'h0000_00E0, 1'b0);  // third break
    offer_span(16'd3100, 7'd120, 32'h0000_00E0, 1'b0); // size limit
    offer_span(16'hFFFE, 7'd1, 32'h0000_00E0, 1'b0);
    offer_span(16'hFFFF, 7'd1, 32'h0000_00E0, 1'b1);   // last break

    // zero size limit: every extension cuts
    wait_ranges_drained();
    dcfg.max_pdu_bytes = 8'h00;
    program_config(dcfg);
    offer_span(16'd50, 7'd1, 32'h0000_0001, 1'b0);
    offer_span(16'd51, 7'd1, 32'h0000_0001, 1'b1);

    // random phases
    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_ranges_drained();
      program_config(pick_config(phase));
      tx_eager = (phase % 3 == 1);
      rx_eager = (phase % 4 == 2);
      if (phase == 5) begin
        // receiver holds off while spans keep coming
        tx_eager    = 1'b1;
        rx_hold_req = 1'b1;
      end
      target = spans_sent + PhaseSpans;
      while (spans_sent < target) send_group();
    end

    wait_ranges_drained();
    if (mismatches == 0 && ranges_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
